// File: hw/rtl/ptab_pkg.sv
`timescale 1ns / 1ps

package ptab_pkg;

   localparam int ID_W   = 32;
   localparam int DATA_W = 64;
   localparam int LEN_W  = 4;
   localparam int STAT_W = 3;

   localparam int DEF_ENTRIES     = 32;
   localparam int DEF_VALUE_BYTES = 8;

   // request kinds
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_SET = 1'b1;

   // result codes
   localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd2;
   localparam logic [STAT_W-1:0] ST_ADDED     = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic              req_type;
      logic [ID_W-1:0]   param_id;
      logic [DATA_W-1:0] value_in;
      logic [LEN_W-1:0]  value_len_in;
   } ptab_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] value_out;
      logic [LEN_W-1:0]  value_len_out;
   } ptab_rsp_type;

   // classified request between front and back
   typedef struct packed {
      logic              is_set;
      logic [ID_W-1:0]   param_id;
      logic [DATA_W-1:0] value;
      logic [LEN_W-1:0]  value_len;
   } ptab_cmd_type;

endpackage

// File: hw/rtl/ptab_ram.sv
`timescale 1ns / 1ps

module ptab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ptab_front.sv
`timescale 1ns / 1ps

module ptab_front #(
   parameter int VALUE_BYTES = ptab_pkg::DEF_VALUE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ptab_pkg::ptab_req_type req_data,
   output logic                  cmd_valid,
   input  logic                  cmd_pop,
   output ptab_pkg::ptab_cmd_type cmd_data
);

   import ptab_pkg::*;

   localparam int QDEPTH = 2;

   ptab_cmd_type     q_ff [QDEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   logic             pop;
   logic [LEN_W-1:0] len_sat;
   ptab_cmd_type     cmd_new;

   // saturate length, clear bytes past it
   always_comb begin
      if (req_data.value_len_in > LEN_W'(VALUE_BYTES)) begin
         len_sat = LEN_W'(VALUE_BYTES);
      end else begin
         len_sat = req_data.value_len_in;
      end
      cmd_new.is_set    = (req_data.req_type == REQ_SET);
      cmd_new.param_id  = req_data.param_id;
      cmd_new.value_len = len_sat;
      for (int b = 0; b < DATA_W / 8; b++) begin
         if (LEN_W'(b) < len_sat) begin
            cmd_new.value[b*8 +: 8] = req_data.value_in[b*8 +: 8];
         end else begin
            cmd_new.value[b*8 +: 8] = 8'h00;
         end
      end
   end

   assign req_stall = (count_ff == 2'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: hw/rtl/ptab_back.sv
`timescale 1ns / 1ps

module ptab_back #(
   parameter int ENTRIES     = ptab_pkg::DEF_ENTRIES,
   parameter int VALUE_BYTES = ptab_pkg::DEF_VALUE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_pop,
   input  ptab_pkg::ptab_cmd_type cmd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ptab_pkg::ptab_rsp_type rsp_data
);

   import ptab_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int VW    = VALUE_BYTES * 8;
   localparam int RAM_W = ID_W + LEN_W + VW;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]         state_ff, state_in;
   ptab_cmd_type       cmd_ff, cmd_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [LEN_W-1:0]   hit_len_ff, hit_len_in;
   logic [VW-1:0]      hit_val_ff, hit_val_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [ENTRIES-1:0] used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ptab_rsp_type       rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [RAM_W-1:0]   wr_data;
   logic [RAM_W-1:0]   rd_data;
   logic [ID_W-1:0]    rd_id;
   logic [LEN_W-1:0]   rd_len;
   logic [VW-1:0]      rd_val;
   logic               chk_used;
   logic               commit;

   assign rd_id  = rd_data[VW + LEN_W +: ID_W];
   assign rd_len = rd_data[VW +: LEN_W];
   assign rd_val = rd_data[VW-1:0];

   ptab_ram #(
      .WIDTH (RAM_W),
      .DEPTH (ENTRIES),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign chk_used = used_ff[chk_idx_ff];
   assign commit   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_len_in   = hit_len_ff;
      hit_val_in   = hit_val_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = hit_ff ? hit_idx_ff : free_idx_ff;
      wr_data      = {cmd_ff.param_id, cmd_ff.value_len, cmd_ff.value[VW-1:0]};

      // compare the entry read in the previous cycle
      if (chk_valid_ff) begin
         if (chk_used) begin
            if (!hit_ff && rd_id == cmd_ff.param_id) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
               hit_len_in = rd_len;
               hit_val_in = rd_val;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               addr_in  = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            chk_valid_in = 1'b1;
            chk_idx_in   = addr_ff;
            if (addr_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (!cmd_ff.is_set) begin
                  if (hit_ff) begin
                     rsp_data_in.status        = ST_FOUND;
                     rsp_data_in.value_out     = DATA_W'(hit_val_ff);
                     rsp_data_in.value_len_out = hit_len_ff;
                  end else begin
                     rsp_data_in.status = ST_NOT_FOUND;
                  end
               end else if (hit_ff) begin
                  rsp_data_in.status = ST_UPDATED;
                  wr_en              = 1'b1;
               end else if (free_ff) begin
                  rsp_data_in.status    = ST_ADDED;
                  wr_en                 = 1'b1;
                  used_in[free_idx_ff]  = 1'b1;
               end else begin
                  rsp_data_in.status = ST_FULL;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_valid_ff <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_len_ff  <= hit_len_in;
      hit_val_ff  <= hit_val_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/parameter_id_table_core.sv
`timescale 1ns / 1ps

// parameter table keyed by a 32-bit id, ENTRIES entries deep. a get request returns the value
// and byte length stored for the id (status found) or reports not found with zero value and
// length; a set request overwrites the first used entry with that id (updated), else claims the
// lowest free entry (added), else reports table full and drops the value. set lengths above
// VALUE_BYTES are saturated and bytes past the length are stored as zero. reset clears all used
// flags at once; no clearing pass is needed. each request passes through the back end in order:
// pick-up from the queue, a scan of every entry through the single read port of the entry
// memory, a drain of the registered read, then the write and load of the result, which waits
// while a held result is stalled. a two-deep request queue and a result register let the
// requester and the consumer run ahead of or behind the scan.
module parameter_id_table_core #(
   parameter int ENTRIES     = ptab_pkg::DEF_ENTRIES,
   parameter int VALUE_BYTES = ptab_pkg::DEF_VALUE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ptab_pkg::ptab_req_type req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ptab_pkg::ptab_rsp_type rsp_data
);

   import ptab_pkg::*;

   // classified request handed from the queue to the scan engine
   logic         cmd_valid;
   logic         cmd_pop;
   ptab_cmd_type cmd_data;

   // front: length saturation, byte masking and the request queue
   ptab_front #(
      .VALUE_BYTES (VALUE_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   // back: linear scan of the entry memory, commit of set, result register
   ptab_back #(
      .ENTRIES     (ENTRIES),
      .VALUE_BYTES (VALUE_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hw/rtl/ptab_checker.sv
`timescale 1ns / 1ps

module ptab_checker #(
   parameter int VALUE_BYTES = ptab_pkg::DEF_VALUE_BYTES
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input ptab_pkg::ptab_rsp_type rsp_data
);

   import ptab_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_zero_when_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_FOUND
      |-> rsp_data.value_out == '0 && rsp_data.value_len_out == '0)
      else $error("value returned without a hit");

   a_found_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FOUND
      |-> rsp_data.value_len_out <= LEN_W'(VALUE_BYTES))
      else $error("stored length out of range");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_FULL)
      else $error("bad status code");

endmodule

bind parameter_id_table_core ptab_checker #(
   .VALUE_BYTES (VALUE_BYTES)
) u_ptab_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: bench/parameter_id_table_core_tb.sv
`timescale 1ns / 1ps

module parameter_id_table_core_tb;
   import ptab_pkg::*;

   localparam int ENTRIES     = DEF_ENTRIES;
   localparam int VALUE_BYTES = DEF_VALUE_BYTES;
   // one request's pass through the back end: pick-up, scan of every entry, drain and result
   localparam int SCAN_CYCLES = ENTRIES + 3;
   // far above the slowest legal run (about 1100 requests with both sides idling)
   localparam int CYCLE_LIMIT = 500000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   ptab_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   ptab_rsp_type rsp_data;

   // idle rates in percent, changed between phases by the test tasks
   int unsigned sender_idle_pct = 0;
   int unsigned rsp_idle_pct    = 0;
   // nonzero asks the response side for one long hold-off of that many cycles
   int unsigned hold_cycles_request = 0;
   int unsigned error_count = 0;

   // shadow copy of the parameter table
   logic              tab_used  [ENTRIES] = '{default: 1'b0};
   logic [ID_W-1:0]   tab_id    [ENTRIES] = '{default: '0};
   logic [DATA_W-1:0] tab_value [ENTRIES];
   logic [LEN_W-1:0]  tab_len   [ENTRIES];

   // replies owed by the table, oldest first
   ptab_rsp_type predicted_replies [$];
   ptab_rsp_type want_rsp;

   parameter_id_table_core #(
      .ENTRIES     (ENTRIES),
      .VALUE_BYTES (VALUE_BYTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // apply one accepted request to the shadow table and return the reply it owes
   function automatic ptab_rsp_type apply_table_request(input ptab_req_type item);
      ptab_rsp_type     reply;
      int               hit;
      int               free_idx;
      logic [LEN_W-1:0] len;
      logic [DATA_W-1:0] val;
      reply    = '0;
      hit      = -1;
      free_idx = -1;
      // first used entry with a matching id, lowest unused entry
      for (int i = 0; i < ENTRIES; i++) begin
         if (tab_used[i]) begin
            if (hit < 0 && tab_id[i] == item.param_id) hit = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      if (item.req_type == REQ_GET) begin
         if (hit >= 0) begin
            reply.status        = ST_FOUND;
            reply.value_out     = tab_value[hit];
            reply.value_len_out = tab_len[hit];
         end else begin
            reply.status = ST_NOT_FOUND;
         end
         return reply;
      end
      // set: saturate the length, zero the bytes past it
      len = (item.value_len_in > VALUE_BYTES) ? LEN_W'(VALUE_BYTES) : item.value_len_in;
      val = item.value_in;
      for (int b = 0; b < DATA_W / 8; b++)
         if (b >= len) val[8*b +: 8] = 8'h00;
      if (hit >= 0) begin
         tab_value[hit] = val;
         tab_len[hit]   = len;
         reply.status   = ST_UPDATED;
      end else if (free_idx >= 0) begin
         tab_used[free_idx]  = 1'b1;
         tab_id[free_idx]    = item.param_id;
         tab_value[free_idx] = val;
         tab_len[free_idx]   = len;
         reply.status        = ST_ADDED;
      end else begin
         // table full: value dropped, nothing changes
         reply.status = ST_FULL;
      end
      return reply;
   endfunction

   function automatic ptab_req_type make_req(input logic kind, input logic [ID_W-1:0] id,
                                             input logic [DATA_W-1:0] val,
                                             input logic [LEN_W-1:0] len);
      ptab_req_type item;
      item.req_type     = kind;
      item.param_id     = id;
      item.value_in     = val;
      item.value_len_in = len;
      return item;
   endfunction

   // mostly ids already stored, so gets hit and sets update; otherwise a fresh id
   function automatic logic [ID_W-1:0] pick_param_id(input int unsigned fresh_pct);
      int unsigned stored_count;
      int unsigned nth;
      stored_count = 0;
      foreach (tab_used[i]) if (tab_used[i]) stored_count++;
      if (stored_count != 0 && $urandom_range(99) >= fresh_pct) begin
         nth = $urandom_range(stored_count - 1);
         foreach (tab_used[i]) begin
            if (tab_used[i]) begin
               if (nth == 0) return tab_id[i];
               nth--;
            end
         end
      end
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic ptab_req_type random_request();
      ptab_req_type item;
      item.req_type = 1'($urandom_range(1));
      item.param_id = pick_param_id(item.req_type == REQ_SET ? 40 : 30);
      item.value_in = {$urandom, $urandom};
      // lengths mostly legal, now and then past VALUE_BYTES
      item.value_len_in = ($urandom_range(7) == 0) ? LEN_W'($urandom_range(15))
                                                   : LEN_W'($urandom_range(VALUE_BYTES));
      return item;
   endfunction

   // offer one request, hold it until accepted, then record the reply it owes
   task automatic send_request(input ptab_req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_replies.push_back(apply_table_request(item));
   endtask

   // lookups on an empty table, id 0 included although unused shadow entries hold id 0
   task automatic test_empty_lookup();
      send_request(make_req(REQ_GET, '0, '0, '0));
      send_request(make_req(REQ_GET, '1, '1, '1));
      send_request(make_req(REQ_GET, 32'h0000_0001, 64'h0123_4567_89ab_cdef, 4'd8));
   endtask

   // add, find, update and find again at the id extremes
   task automatic test_add_update_lookup();
      send_request(make_req(REQ_SET, '0, '1, 4'd8));
      send_request(make_req(REQ_SET, '1, 64'hfedc_ba98_7654_3210, 4'd8));
      send_request(make_req(REQ_GET, '0, '0, '0));
      send_request(make_req(REQ_GET, '1, '1, 4'hf));
      send_request(make_req(REQ_SET, '1, 64'ha5a5_5a5a_c3c3_3c3c, 4'd8));
      send_request(make_req(REQ_GET, '1, '0, '0));
      // miss while entries are in use
      send_request(make_req(REQ_GET, 32'h8000_0000, '0, '0));
   endtask

   // length saturation and zeroing of bytes past the length
   task automatic test_value_length();
      send_request(make_req(REQ_SET, '0, '1, 4'd3));
      send_request(make_req(REQ_GET, '0, '0, '0));
      send_request(make_req(REQ_SET, 32'h1234_5678, '1, 4'd0));
      send_request(make_req(REQ_GET, 32'h1234_5678, '0, '0));
      send_request(make_req(REQ_SET, 32'h1234_5678, '1, 4'hf));
      send_request(make_req(REQ_GET, 32'h1234_5678, '0, '0));
      send_request(make_req(REQ_SET, '0, 64'h8899_aabb_ccdd_eeff, 4'd9));
      send_request(make_req(REQ_GET, '0, '0, '0));
      send_request(make_req(REQ_SET, '0, 64'h8899_aabb_ccdd_eeff, 4'd1));
      send_request(make_req(REQ_GET, '0, '1, 4'd8));
   endtask

   // random gets and sets; the table fills early and stays full
   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned count);
      sender_idle_pct = send_pct;
      rsp_idle_pct    = recv_pct;
      repeat (count) send_request(random_request());
   endtask

   // response side holds off while requests keep coming, so the queue fills and stalls
   task automatic test_backpressure();
      sender_idle_pct     = 0;
      rsp_idle_pct        = 0;
      hold_cycles_request = 8 * SCAN_CYCLES;
      repeat (12) send_request(random_request());
   endtask

   // response side: random stall, or one long hold-off counted here
   initial begin : rsp_side
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles_request != 0) begin
            hold_left           = hold_cycles_request;
            hold_cycles_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // compare every accepted reply with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_replies.size() == 0) begin
            $error("reply with none owed: status %0d value %h len %0d",
                   rsp_data.status, rsp_data.value_out, rsp_data.value_len_out);
            error_count++;
         end else begin
            want_rsp = predicted_replies.pop_front();
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d", want_rsp.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.value_out !== want_rsp.value_out) begin
               $error("value_out: expected %h, got %h", want_rsp.value_out,
                      rsp_data.value_out);
               error_count++;
            end
            if (rsp_data.value_len_out !== want_rsp.value_len_out) begin
               $error("value_len_out: expected %0d, got %0d", want_rsp.value_len_out,
                      rsp_data.value_len_out);
               error_count++;
            end
         end
      end
   end

   // hard stop if the table hangs
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : run
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_lookup();
      test_add_update_lookup();
      test_value_length();
      test_random_traffic(31, 76, 340);
      test_random_traffic(76, 31, 340);
      test_backpressure();
      test_random_traffic(0, 0, 340);
      req_valid <= 1'b0;

      // drain, then give a stray extra reply time to show up
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (2 * SCAN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
